// ----- rtl/core/ddd_wr_pkg.sv -----
package ddd_wr_pkg;

    localparam int NUM_DIGITS  = 8;
    localparam int FRAC_BITS   = 8;
    localparam int VALUE_W     = 27;
    localparam int INT_W       = VALUE_W - FRAC_BITS;
    localparam int POS_W       = 3;
    localparam int ADDR_W      = 4;
    localparam int CODE_W      = 8;
    localparam int SAT_W       = 10;

    localparam logic [POS_W-1:0]  HI_MAX     = POS_W'(NUM_DIGITS - 1);
    localparam logic [POS_W-1:0]  FIX_LO_MAX = POS_W'(NUM_DIGITS - 4);
    localparam logic [SAT_W-1:0]  INT_SAT    = SAT_W'(999);
    localparam logic [CODE_W-1:0] CODE_BLANK = 8'h0F;
    localparam logic [CODE_W-1:0] CODE_POINT = 8'h80;

    // Reciprocal of ten, exact for any dividend below 2^32 with a shift of 35.
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          PROD_W      = VALUE_W + 32;

    typedef enum logic [1:0] {
        STEP_TENTHS = 2'd0,
        STEP_ONES   = 2'd1,
        STEP_TENS   = 2'd2,
        STEP_HUND   = 2'd3
    } t_fix_step_e;

endpackage

// ----- rtl/core/decimal_digit_display_writer.sv -----
// Decimal digit display writer: turns one number into a run of digit-register
// writes (address, code-B byte) for a seven-segment driver.
//
// Input: an item (mode, low position, high position, value) is taken at a rising
// edge where start is high and busy is low. busy rises in the next cycle, unless
// the item gives no writes, and stays high while the run is produced.
// Output: each write appears for exactly one cycle with o_strobe high;
// o_last marks the final write of the run. The receiver cannot stall.
// Integer mode gives high-low+1 writes (high clamped to the top position),
// or none when low is above high. Fixed mode always gives four writes.
// Timing: one write per cycle from the shared divide-by-ten unit (a 27 x 32
// reciprocal multiply); each write is registered out of ST_RUN, which the start
// transaction enters. A new item is taken only in ST_IDLE, never while a run is
// still producing its writes; an item with no writes never leaves ST_IDLE.
// Reset: synchronous, active low; returns to idle and drops o_strobe.
module decimal_digit_display_writer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic [ddd_wr_pkg::POS_W-1:0]      i_lo_pos,
    input  logic [ddd_wr_pkg::POS_W-1:0]      i_hi_pos,
    input  logic [ddd_wr_pkg::VALUE_W-1:0]    i_value,
    output logic                              o_strobe,
    output logic [ddd_wr_pkg::ADDR_W-1:0]     o_digit_address,
    output logic [ddd_wr_pkg::CODE_W-1:0]     o_digit_code,
    output logic                              o_last
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state_e;

    t_state_e                          r_state, n_state;
    logic                              r_mode, n_mode;
    logic [ddd_wr_pkg::VALUE_W-1:0]    r_val, n_val;
    logic [ddd_wr_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [ddd_wr_pkg::POS_W-1:0]      r_hi, n_hi;
    ddd_wr_pkg::t_fix_step_e           r_step, n_step;
    logic [3:0]                        r_tenths, n_tenths;
    logic                              r_blank_t, n_blank_t;
    logic                              r_blank_h, n_blank_h;
    logic                              r_strobe, n_strobe;
    logic [ddd_wr_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic [ddd_wr_pkg::CODE_W-1:0]     r_code, n_code;
    logic                              r_last, n_last;

    logic [ddd_wr_pkg::PROD_W-1:0]     prod;
    logic [ddd_wr_pkg::VALUE_W-1:0]    quot;
    logic [ddd_wr_pkg::VALUE_W-1:0]    rem_full;
    logic [3:0]                        rem;

    logic [ddd_wr_pkg::POS_W-1:0]      hi_clamped;
    logic [ddd_wr_pkg::POS_W-1:0]      lo_fixed;
    logic [ddd_wr_pkg::INT_W-1:0]      int_part;
    logic [ddd_wr_pkg::SAT_W-1:0]      int_sat;
    logic [ddd_wr_pkg::FRAC_BITS-1:0]  frac;
    logic [ddd_wr_pkg::FRAC_BITS+3:0]  frac_x10;
    logic                              run_last;
    logic [ddd_wr_pkg::ADDR_W-1:0]     cur_addr;

    // Shared divide-by-ten unit on the working value.
    always_comb begin
        prod     = ddd_wr_pkg::PROD_W'(r_val)
                 * ddd_wr_pkg::PROD_W'(ddd_wr_pkg::DIV10_RECIP);
        quot     = ddd_wr_pkg::VALUE_W'(prod >> ddd_wr_pkg::DIV10_SHIFT);
        rem_full = r_val - (quot << 3) - (quot << 1);
        rem      = rem_full[3:0];
    end

    // Load-time preparation of the item.
    always_comb begin
        hi_clamped = (i_hi_pos > ddd_wr_pkg::HI_MAX) ? ddd_wr_pkg::HI_MAX : i_hi_pos;
        lo_fixed   = (i_lo_pos > ddd_wr_pkg::FIX_LO_MAX) ? ddd_wr_pkg::FIX_LO_MAX
                                                         : i_lo_pos;
        int_part   = i_value[ddd_wr_pkg::VALUE_W-1:ddd_wr_pkg::FRAC_BITS];
        int_sat    = (int_part > ddd_wr_pkg::INT_W'(ddd_wr_pkg::INT_SAT))
                   ? ddd_wr_pkg::INT_SAT : ddd_wr_pkg::SAT_W'(int_part);
        frac       = i_value[ddd_wr_pkg::FRAC_BITS-1:0];
        frac_x10   = ({4'd0, frac} << 3) + ({4'd0, frac} << 1);
    end

    always_comb begin
        cur_addr = {1'b0, r_pos} + ddd_wr_pkg::ADDR_W'(1);
        run_last = r_mode ? (r_step == ddd_wr_pkg::STEP_HUND) : (r_pos == r_hi);
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_val     = r_val;
        n_pos     = r_pos;
        n_hi      = r_hi;
        n_step    = r_step;
        n_tenths  = r_tenths;
        n_blank_t = r_blank_t;
        n_blank_h = r_blank_h;
        n_strobe  = 1'b0;
        n_addr    = r_addr;
        n_code    = r_code;
        n_last    = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode    = i_mode;
                    n_hi      = hi_clamped;
                    n_step    = ddd_wr_pkg::STEP_TENTHS;
                    n_tenths  = frac_x10[ddd_wr_pkg::FRAC_BITS+3:ddd_wr_pkg::FRAC_BITS];
                    n_blank_t = (int_sat < ddd_wr_pkg::SAT_W'(10));
                    n_blank_h = (int_sat < ddd_wr_pkg::SAT_W'(100));
                    if (i_mode) begin
                        n_pos   = lo_fixed;
                        n_val   = ddd_wr_pkg::VALUE_W'(int_sat);
                        n_state = ST_RUN;
                    end else begin
                        n_pos = i_lo_pos;
                        n_val = i_value;
                        // drop the item when the range is empty
                        if (i_lo_pos <= hi_clamped) begin
                            n_state = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN: begin
                n_strobe = 1'b1;
                n_addr   = cur_addr;
                n_last   = run_last;
                n_pos    = r_pos + ddd_wr_pkg::POS_W'(1);
                if (r_mode) begin
                    n_step = ddd_wr_pkg::t_fix_step_e'(r_step + 2'd1);
                    unique case (r_step)
                        ddd_wr_pkg::STEP_TENTHS: n_code = {4'd0, r_tenths};
                        ddd_wr_pkg::STEP_ONES:   n_code = ddd_wr_pkg::CODE_POINT | {4'd0, rem};
                        ddd_wr_pkg::STEP_TENS:   n_code = r_blank_t ? ddd_wr_pkg::CODE_BLANK
                                                                    : {4'd0, rem};
                        ddd_wr_pkg::STEP_HUND:   n_code = r_blank_h ? ddd_wr_pkg::CODE_BLANK
                                                                    : {4'd0, rem};
                        default:                 n_code = ddd_wr_pkg::CODE_BLANK;
                    endcase
                    // hold the value while the tenths digit goes out
                    if (r_step != ddd_wr_pkg::STEP_TENTHS) begin
                        n_val = quot;
                    end
                end else begin
                    n_code = {4'd0, rem};
                    n_val  = quot;
                end
                if (run_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_mode    <= n_mode;
        r_val     <= n_val;
        r_pos     <= n_pos;
        r_hi      <= n_hi;
        r_step    <= n_step;
        r_tenths  <= n_tenths;
        r_blank_t <= n_blank_t;
        r_blank_h <= n_blank_h;
        r_addr    <= n_addr;
        r_code    <= n_code;
        r_last    <= n_last;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_strobe        = r_strobe;
    assign o_digit_address = r_addr;
    assign o_digit_code    = r_code;
    assign o_last          = r_last;

endmodule

// ----- dv/tb_decimal_digit_display_writer.sv -----
`timescale 1ns / 100ps

module tb_decimal_digit_display_writer;

    localparam logic MODE_INT = 1'b0;
    localparam logic MODE_FIX = 1'b1;

    localparam int RANDOM_ITEMS = 210;
    localparam int QUIET_TAIL   = 30;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic                           mode;
        logic [ddd_wr_pkg::POS_W-1:0]   lo_pos;
        logic [ddd_wr_pkg::POS_W-1:0]   hi_pos;
        logic [ddd_wr_pkg::VALUE_W-1:0] value;
        bit                             drain;
    } t_digit_req;

    typedef struct {
        logic [ddd_wr_pkg::ADDR_W-1:0] addr;
        logic [ddd_wr_pkg::CODE_W-1:0] code;
        logic                          last;
    } t_digit_write;

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           start           = 1'b0;
    logic                           i_mode          = 1'b0;
    logic [ddd_wr_pkg::POS_W-1:0]   i_lo_pos        = '0;
    logic [ddd_wr_pkg::POS_W-1:0]   i_hi_pos        = '0;
    logic [ddd_wr_pkg::VALUE_W-1:0] i_value         = '0;
    logic                           busy;
    logic                           o_strobe;
    logic [ddd_wr_pkg::ADDR_W-1:0]  o_digit_address;
    logic [ddd_wr_pkg::CODE_W-1:0]  o_digit_code;
    logic                           o_last;

    t_digit_req   pending_reqs[$];
    t_digit_write expected_writes[$];

    bit took_req    = 1'b0;
    int error_count = 0;
    int stall_count = 0;
    int gap_left    = 0;
    int gap_pct     = 0;
    int sent_count  = 0;

    decimal_digit_display_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_lo_pos        (i_lo_pos),
        .i_hi_pos        (i_hi_pos),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_digit_address (o_digit_address),
        .o_digit_code    (o_digit_code),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Expand one transaction into the digit-register writes it should produce.
    task automatic queue_digit_writes(input logic mode,
                                      input logic [ddd_wr_pkg::POS_W-1:0] lo_in,
                                      input logic [ddd_wr_pkg::POS_W-1:0] hi_in,
                                      input logic [ddd_wr_pkg::VALUE_W-1:0] value);
        int                             lo;
        int                             hi;
        int                             whole;
        int                             tenths;
        logic [ddd_wr_pkg::VALUE_W-1:0] rest;
        logic [ddd_wr_pkg::CODE_W-1:0]  tens_code;
        logic [ddd_wr_pkg::CODE_W-1:0]  hund_code;
        lo = lo_in;
        hi = hi_in;
        if (mode == MODE_INT) begin
            if (hi > ddd_wr_pkg::NUM_DIGITS - 1)
                hi = ddd_wr_pkg::NUM_DIGITS - 1;
            rest = value;
            for (int p = lo; p <= hi; p++) begin
                expected_writes.push_back('{ddd_wr_pkg::ADDR_W'(p + 1),
                                            ddd_wr_pkg::CODE_W'(rest % 10), p == hi});
                rest = rest / 10;
            end
        end else begin
            if (lo > ddd_wr_pkg::NUM_DIGITS - 4)
                lo = ddd_wr_pkg::NUM_DIGITS - 4;
            whole  = int'(value >> ddd_wr_pkg::FRAC_BITS);
            tenths = (int'(value & ((ddd_wr_pkg::VALUE_W'(1) << ddd_wr_pkg::FRAC_BITS) - 1))
                      * 10) >> ddd_wr_pkg::FRAC_BITS;
            if (whole > 999)
                whole = 999;
            tens_code = (whole >= 10)  ? ddd_wr_pkg::CODE_W'((whole / 10) % 10)
                                       : ddd_wr_pkg::CODE_BLANK;
            hund_code = (whole >= 100) ? ddd_wr_pkg::CODE_W'(whole / 100)
                                       : ddd_wr_pkg::CODE_BLANK;
            expected_writes.push_back('{ddd_wr_pkg::ADDR_W'(lo + 1),
                                        ddd_wr_pkg::CODE_W'(tenths), 1'b0});
            expected_writes.push_back('{ddd_wr_pkg::ADDR_W'(lo + 2),
                                        ddd_wr_pkg::CODE_W'(whole % 10)
                                        | ddd_wr_pkg::CODE_POINT, 1'b0});
            expected_writes.push_back('{ddd_wr_pkg::ADDR_W'(lo + 3), tens_code, 1'b0});
            expected_writes.push_back('{ddd_wr_pkg::ADDR_W'(lo + 4), hund_code, 1'b1});
        end
    endtask

    task automatic add_req(input logic mode, input int lo, input int hi,
                           input logic [ddd_wr_pkg::VALUE_W-1:0] value, input bit drain);
        pending_reqs.push_back('{mode, ddd_wr_pkg::POS_W'(lo), ddd_wr_pkg::POS_W'(hi),
                                 value, drain});
    endtask

    function automatic logic [ddd_wr_pkg::VALUE_W-1:0] fix_value(input int whole,
                                                                 input int frac);
        return (ddd_wr_pkg::VALUE_W'(whole) << ddd_wr_pkg::FRAC_BITS)
             | ddd_wr_pkg::VALUE_W'(frac & ((1 << ddd_wr_pkg::FRAC_BITS) - 1));
    endfunction

    function automatic logic [ddd_wr_pkg::VALUE_W-1:0] random_value();
        int                             nbits;
        logic [ddd_wr_pkg::VALUE_W-1:0] mask;
        nbits = $urandom_range(1, ddd_wr_pkg::VALUE_W);
        mask  = (ddd_wr_pkg::VALUE_W'(1) << nbits) - ddd_wr_pkg::VALUE_W'(1);
        return ddd_wr_pkg::VALUE_W'($urandom) & mask;
    endfunction

    // Driver: present transactions at the falling edge, hold until taken.
    always @(negedge i_clk) begin
        logic       nxt_start;
        t_digit_req req;
        nxt_start = start;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (!start || took_req) begin
            nxt_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                if (pending_reqs[0].drain && (expected_writes.size() != 0 || busy || took_req)) begin
                    // hold until the block has flushed every outstanding write
                end else if (pending_reqs.size() > QUIET_TAIL && gap_pct > 0 &&
                             $urandom_range(1, 100) <= gap_pct) begin
                    gap_left = $urandom_range(0, 15);
                end else begin
                    req = pending_reqs.pop_front();
                    nxt_start = 1'b1;
                    i_mode    <= req.mode;
                    i_lo_pos  <= req.lo_pos;
                    i_hi_pos  <= req.hi_pos;
                    i_value   <= req.value;
                    sent_count++;
                    if (sent_count % 32 == 0)
                        case ($urandom_range(0, 2))
                            0: gap_pct = 0;
                            1: gap_pct = 15;
                            default: gap_pct = 40;
                        endcase
                end
            end
        end
        start <= nxt_start;
    end

    // Monitor: predict on accepted transactions, check every strobed write.
    always @(posedge i_clk) begin
        t_digit_write exp_wr;
        took_req <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy)
            queue_digit_writes(i_mode, i_lo_pos, i_hi_pos, i_value);
        if (i_rst_n && o_strobe) begin
            if (expected_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write addr=%0d code=%02h last=%0b",
                                          o_digit_address, o_digit_code, o_last));
            end else begin
                exp_wr = expected_writes.pop_front();
                if (o_digit_address !== exp_wr.addr)
                    report_mismatch($sformatf("digit_address %0d, expected %0d",
                                              o_digit_address, exp_wr.addr));
                if (o_digit_code !== exp_wr.code)
                    report_mismatch($sformatf("digit_code %02h, expected %02h (addr %0d)",
                                              o_digit_code, exp_wr.code, exp_wr.addr));
                if (o_last !== exp_wr.last)
                    report_mismatch($sformatf("last %0b, expected %0b (addr %0d)",
                                              o_last, exp_wr.last, exp_wr.addr));
            end
        end
        if ((start && !busy) || o_strobe)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL decimal_digit_display_writer");
            $finish;
        end
    end

    initial begin
        int lo;
        int sel;
        int whole;

        // directed corners
        add_req(MODE_INT, 0, 7, '0, 1'b0);
        add_req(MODE_INT, 0, 7, '1, 1'b0);
        add_req(MODE_INT, 0, 7, 27'd12345678, 1'b0);
        add_req(MODE_INT, 0, 7, 27'd99999999, 1'b0);
        add_req(MODE_INT, 3, 3, 27'd987, 1'b0);
        add_req(MODE_INT, 7, 7, 27'h5555555, 1'b0);
        add_req(MODE_INT, 0, 0, 27'd9, 1'b0);
        add_req(MODE_INT, 2, 6, 27'h2AAAAAA, 1'b0);
        add_req(MODE_INT, 1, 4, 27'h4000000, 1'b0);
        add_req(MODE_INT, 5, 2, 27'd4321, 1'b0);   // low above high: no writes
        add_req(MODE_INT, 7, 0, '1, 1'b0);
        add_req(MODE_FIX, 0, 0, '0, 1'b0);
        add_req(MODE_FIX, 4, 7, '1, 1'b0);         // saturated integer part
        add_req(MODE_FIX, 7, 3, fix_value(9, 8'h80), 1'b0);   // low clamped
        add_req(MODE_FIX, 5, 0, fix_value(10, 8'h19), 1'b0);
        add_req(MODE_FIX, 2, 7, fix_value(99, 8'h1A), 1'b0);
        add_req(MODE_FIX, 1, 5, fix_value(100, 8'hFF), 1'b0);
        add_req(MODE_FIX, 3, 1, fix_value(999, 8'hE6), 1'b0);
        add_req(MODE_FIX, 0, 6, fix_value(1000, 8'h00), 1'b0);
        add_req(MODE_FIX, 6, 2, fix_value(0, 8'h33), 1'b1);

        // random: mostly well-formed runs, some empty ranges
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                lo = $urandom_range(0, 7);
                add_req(MODE_INT, lo, $urandom_range(lo, 7), random_value(), sel < 2);
            end else if (sel < 70) begin
                lo = $urandom_range(1, 7);
                add_req(MODE_INT, lo, $urandom_range(0, lo - 1), random_value(), 1'b0);
            end else begin
                whole = ($urandom_range(0, 3) == 0)
                      ? int'($urandom_range(0, (1 << ddd_wr_pkg::INT_W) - 1))
                      : int'($urandom_range(0, 1100));
                add_req(MODE_FIX, $urandom_range(0, 7), $urandom_range(0, 7),
                        fix_value(whole, $urandom_range(0, (1 << ddd_wr_pkg::FRAC_BITS) - 1)),
                        sel > 97);
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (pending_reqs.size() != 0 || start);
        while (expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("PASS decimal_digit_display_writer");
        else
            $display("FAIL decimal_digit_display_writer");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ddd_wr_pkg.sv
rtl/core/decimal_digit_display_writer.sv
dv/tb_decimal_digit_display_writer.sv
